// File: rtl/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants of the bit-serial prefix-code decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

   localparam int SYM_W            = 8;
   localparam int CODE_W           = 16;
   localparam int LEN_W            = 5;
   localparam int TABLE_DEPTH      = 256;
   localparam int DEF_MAX_CODE_LEN = 16;
   localparam int COUNT_CAP        = 31;

   // operation codes of an input word
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // result kinds
   localparam logic KIND_SYMBOL   = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // one code table entry
   typedef struct packed {
      logic              valid;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
   } entry_type;

   // accumulator controls
   typedef struct packed {
      logic shift;
      logic clear;
      logic din;
   } acc_ctl_type;

endpackage

// File: rtl/hbd_table.sv
// ----------------------------------------------------------------------------
// hbd_table
// Code table memory: one entry per symbol, registered read, valid bits in
// flops cleared at reset.
// ----------------------------------------------------------------------------
module hbd_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [hbd_pkg::SYM_W-1:0]    wr_addr,
   input  hbd_pkg::entry_type           wr_entry,
   input  logic [hbd_pkg::SYM_W-1:0]    rd_addr,
   output hbd_pkg::entry_type           rd_entry
);

   logic [hbd_pkg::CODE_W-1:0]      code_mem_ff [hbd_pkg::TABLE_DEPTH];
   logic [hbd_pkg::LEN_W-1:0]       len_mem_ff  [hbd_pkg::TABLE_DEPTH];
   logic [hbd_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [hbd_pkg::CODE_W-1:0]      rd_code_ff;
   logic [hbd_pkg::LEN_W-1:0]       rd_len_ff;
   logic                            rd_valid_ff;

   // write code and length, read them back in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         code_mem_ff[wr_addr] <= wr_entry.code;
         len_mem_ff[wr_addr]  <= wr_entry.length;
      end
      rd_code_ff  <= code_mem_ff[rd_addr];
      rd_len_ff   <= len_mem_ff[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   // hold valid marks, cleared at once by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= wr_entry.valid;
      end
   end

   assign rd_entry.valid  = rd_valid_ff;
   assign rd_entry.code   = rd_code_ff;
   assign rd_entry.length = rd_len_ff;

endmodule

// File: rtl/hbd_accum.sv
// ----------------------------------------------------------------------------
// hbd_accum
// Compressed-bit shift register and saturating bit counter.
// ----------------------------------------------------------------------------
module hbd_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  hbd_pkg::acc_ctl_type        ctl,
   output logic [hbd_pkg::CODE_W-1:0]  acc,
   output logic [hbd_pkg::LEN_W-1:0]   count
);

   localparam logic [hbd_pkg::LEN_W-1:0] CountMax = hbd_pkg::LEN_W'(hbd_pkg::COUNT_CAP);

   logic [hbd_pkg::CODE_W-1:0] acc_ff, acc_in;
   logic [hbd_pkg::LEN_W-1:0]  count_ff, count_in;

   // shift one bit in, or drop everything after a result
   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      priority if (ctl.clear) begin
         acc_in   = '0;
         count_in = '0;
      end else if (ctl.shift) begin
         acc_in   = {acc_ff[hbd_pkg::CODE_W-2:0], ctl.din};
         count_in = (count_ff == CountMax) ? CountMax : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
      end
   end

   assign acc   = acc_ff;
   assign count = count_ff;

endmodule

// File: rtl/hbd_scan.sv
// ----------------------------------------------------------------------------
// hbd_scan
// Sequencer: accepts words, sweeps the code table from the highest symbol
// down for a match, and holds the result word.
// ----------------------------------------------------------------------------
module hbd_scan #(
   parameter int MAX_CODE_LEN = hbd_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic                        req_in_bit,
   output logic                        tbl_wr_en,
   output logic [hbd_pkg::SYM_W-1:0]   tbl_rd_addr,
   input  hbd_pkg::entry_type          tbl_rd_entry,
   output hbd_pkg::acc_ctl_type        acc_ctl,
   input  logic [hbd_pkg::CODE_W-1:0]  acc,
   input  logic [hbd_pkg::LEN_W-1:0]   count,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hbd_pkg::SYM_W-1:0]   rsp_out_symbol,
   output logic                        rsp_out_kind
);

   // bit limit, clamped to 1..31
   localparam int LimitI = (MAX_CODE_LEN > hbd_pkg::COUNT_CAP) ? hbd_pkg::COUNT_CAP :
                           (MAX_CODE_LEN < 1) ? 1 : MAX_CODE_LEN;
   localparam logic [hbd_pkg::LEN_W-1:0] BitLimit = hbd_pkg::LEN_W'(LimitI);
   // longest code length that can ever match
   localparam int CapI = (LimitI < hbd_pkg::CODE_W) ? LimitI : hbd_pkg::CODE_W;
   localparam logic [hbd_pkg::LEN_W-1:0] LenCap = hbd_pkg::LEN_W'(CapI);

   hbd_pkg::state_type state_ff, state_in;

   logic [hbd_pkg::SYM_W-1:0] addr_ff, addr_in;
   logic [hbd_pkg::SYM_W-1:0] rd_sym_ff, rd_sym_in;
   logic                      pend_ff, pend_in;
   logic                      last_ff, last_in;
   logic                      hit_ff, hit_in;
   logic [hbd_pkg::SYM_W-1:0] hit_sym_ff, hit_sym_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [hbd_pkg::SYM_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic                      rsp_kind_ff, rsp_kind_in;

   logic                      accept;
   logic                      entry_hit;
   logic                      emit;
   logic                      slot_free;
   logic [hbd_pkg::CODE_W:0]  mask_wide;
   logic [hbd_pkg::CODE_W-1:0] mask;

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign emit      = hit_ff || (count >= BitLimit);

   // match the entry read last cycle against the accumulated bits
   assign mask_wide = ((hbd_pkg::CODE_W+1)'(1) << tbl_rd_entry.length) -
                      (hbd_pkg::CODE_W+1)'(1);
   assign mask      = mask_wide[hbd_pkg::CODE_W-1:0];
   assign entry_hit = pend_ff && tbl_rd_entry.valid &&
                      (tbl_rd_entry.length != '0) &&
                      (tbl_rd_entry.length <= LenCap) &&
                      (tbl_rd_entry.length == count) &&
                      (((tbl_rd_entry.code ^ acc) & mask) == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hbd_pkg::ST_IDLE: begin
            if (accept && (req_op == hbd_pkg::OP_DECODE)) begin
               state_in = hbd_pkg::ST_SCAN;
            end
         end
         hbd_pkg::ST_SCAN: begin
            if (entry_hit || (pend_ff && last_ff)) begin
               state_in = hbd_pkg::ST_FINISH;
            end
         end
         hbd_pkg::ST_FINISH: begin
            if (!emit || slot_free) begin
               state_in = hbd_pkg::ST_IDLE;
            end
         end
         default: state_in = hbd_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall     = (state_ff != hbd_pkg::ST_IDLE);
      tbl_wr_en     = 1'b0;
      tbl_rd_addr   = addr_ff;
      acc_ctl.shift = 1'b0;
      acc_ctl.clear = 1'b0;
      acc_ctl.din   = req_in_bit;
      addr_in       = addr_ff;
      rd_sym_in     = rd_sym_ff;
      pend_in       = pend_ff;
      last_in       = last_ff;
      hit_in        = hit_ff;
      hit_sym_in    = hit_sym_ff;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_valid_in  = (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         hbd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == hbd_pkg::OP_LOAD) begin
                  tbl_wr_en = 1'b1;
               end else begin
                  acc_ctl.shift = 1'b1;
                  addr_in       = '1;
                  pend_in       = 1'b0;
                  last_in       = 1'b0;
                  hit_in        = 1'b0;
               end
            end
         end
         hbd_pkg::ST_SCAN: begin
            // issue the next read, check the previous one
            pend_in   = 1'b1;
            rd_sym_in = addr_ff;
            last_in   = (addr_ff == '0);
            addr_in   = addr_ff - 1'b1;
            if (entry_hit) begin
               hit_in     = 1'b1;
               hit_sym_in = rd_sym_ff;
            end
         end
         hbd_pkg::ST_FINISH: begin
            if (emit && slot_free) begin
               acc_ctl.clear = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = hit_ff ? hit_sym_ff : '0;
               rsp_kind_in   = hit_ff ? hbd_pkg::KIND_SYMBOL : hbd_pkg::KIND_OVERFLOW;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbd_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      rd_sym_ff     <= rd_sym_in;
      hit_sym_ff    <= hit_sym_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_symbol = rsp_symbol_ff;
   assign rsp_out_kind   = rsp_kind_ff;

endmodule

// File: rtl/huffman_bit_serial_decoder.sv
// A load word writes its table entry directly. A decode word sweeps the table
// one entry per cycle from symbol 255 down through the single read port,
// stopping at the first match or after symbol 0, then waits while the result
// output is stalled. One word is in flight at a time; the result is registered.
// Reset is synchronous and clears the table valid marks at once (no clearing
// pass), the accumulator, the counter and the result valid flag.
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder
// Bit-serial prefix-code decoder with a loadable 256-entry code table.
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder #(
   parameter int MAX_CODE_LEN = hbd_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic                        req_in_bit,
   input  logic [hbd_pkg::SYM_W-1:0]   req_entry_symbol,
   input  logic [hbd_pkg::CODE_W-1:0]  req_entry_code,
   input  logic [hbd_pkg::LEN_W-1:0]   req_entry_length,
   input  logic                        req_entry_valid,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [hbd_pkg::SYM_W-1:0]   rsp_out_symbol,
   output logic                        rsp_out_kind
);

   logic                       tbl_wr_en;
   logic [hbd_pkg::SYM_W-1:0]  tbl_rd_addr;
   hbd_pkg::entry_type         tbl_wr_entry;
   hbd_pkg::entry_type         tbl_rd_entry;
   hbd_pkg::acc_ctl_type       acc_ctl;
   logic [hbd_pkg::CODE_W-1:0] acc;
   logic [hbd_pkg::LEN_W-1:0]  count;

   assign tbl_wr_entry.valid  = req_entry_valid;
   assign tbl_wr_entry.code   = req_entry_code;
   assign tbl_wr_entry.length = req_entry_length;

   hbd_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (tbl_wr_en),
      .wr_addr  (req_entry_symbol),
      .wr_entry (tbl_wr_entry),
      .rd_addr  (tbl_rd_addr),
      .rd_entry (tbl_rd_entry)
   );

   hbd_accum u_accum (
      .clock (clock),
      .reset (reset),
      .ctl   (acc_ctl),
      .acc   (acc),
      .count (count)
   );

   hbd_scan #(
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_in_bit     (req_in_bit),
      .tbl_wr_en      (tbl_wr_en),
      .tbl_rd_addr    (tbl_rd_addr),
      .tbl_rd_entry   (tbl_rd_entry),
      .acc_ctl        (acc_ctl),
      .acc            (acc),
      .count          (count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_symbol (rsp_out_symbol),
      .rsp_out_kind   (rsp_out_kind)
   );

endmodule

// File: bench/huffman_bit_serial_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder_tb
// Drives load and decode words into the prefix-code decoder and scores every
// decoded symbol and overflow against a cycle-free model of the code table
// and bit accumulator, or a typed result. A short directed table comes first,
// then random prefix-free code sets with streams of their code bits, stray
// bits and stray loads, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder_tb;
   import hbd_pkg::*;

   localparam int MODEL_LEN  = DEF_MAX_CODE_LEN;
   localparam int BIT_LIMIT  = (MODEL_LEN > COUNT_CAP) ? COUNT_CAP :
                               ((MODEL_LEN < 1) ? 1 : MODEL_LEN);
   localparam int WORD_GOAL  = 1850;
   localparam int TAIL_WAIT  = 300;

   // one input word
   typedef struct packed {
      logic              op;
      logic              in_bit;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
      logic              usable;
   } word_type;

   // one result word
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             kind;
   } outcome_type;

   // directed row: a word, how often to send it, and an optional typed result
   typedef struct packed {
      logic              op;
      logic              in_bit;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
      logic              usable;
      logic [4:0]        reps;
      logic              typed;
      logic              has_out;
      logic [SYM_W-1:0]  out_symbol;
      logic              out_kind;
   } row_type;

   localparam row_type PLAN [12] = '{
      // empty table after reset: fifteen quiet bits, then the bit limit hits
      '{OP_DECODE, 1'b1, 8'd0, 16'h0000, 5'd0, 1'b0, 5'd15, 1'b1, 1'b0, 8'd0,
        KIND_SYMBOL},
      '{OP_DECODE, 1'b1, 8'd0, 16'h0000, 5'd0, 1'b0, 5'd1, 1'b1, 1'b1, 8'd0,
        KIND_OVERFLOW},
      // code bits above the length are don't-care
      '{OP_LOAD, 1'b0, 8'd0, 16'hFFFE, 5'd1, 1'b1, 5'd1, 1'b1, 1'b0, 8'd0,
        KIND_SYMBOL},
      '{OP_DECODE, 1'b0, 8'd0, 16'h0000, 5'd0, 1'b0, 5'd1, 1'b1, 1'b1, 8'd0,
        KIND_SYMBOL},
      // two entries share a code: the higher symbol wins
      '{OP_LOAD, 1'b0, 8'd200, 16'h0000, 5'd1, 1'b1, 5'd1, 1'b1, 1'b0, 8'd0,
        KIND_SYMBOL},
      '{OP_DECODE, 1'b0, 8'd0, 16'h0000, 5'd0, 1'b0, 5'd1, 1'b1, 1'b1, 8'd200,
        KIND_SYMBOL},
      // zero length, over-long length and an invalid entry never match
      '{OP_LOAD, 1'b1, 8'd255, 16'hFFFF, 5'd0, 1'b1, 5'd1, 1'b1, 1'b0, 8'd0,
        KIND_SYMBOL},
      '{OP_LOAD, 1'b1, 8'd254, 16'h0000, 5'd31, 1'b1, 5'd1, 1'b1, 1'b0, 8'd0,
        KIND_SYMBOL},
      '{OP_LOAD, 1'b0, 8'd201, 16'h0001, 5'd1, 1'b0, 5'd1, 1'b1, 1'b0, 8'd0,
        KIND_SYMBOL},
      '{OP_DECODE, 1'b0, 8'd0, 16'h0000, 5'd0, 1'b0, 5'd1, 1'b1, 1'b1, 8'd200,
        KIND_SYMBOL},
      // widest code on the top symbol, then a bit only the invalid entry fits
      '{OP_LOAD, 1'b1, 8'd255, 16'hFFFF, 5'd16, 1'b1, 5'd1, 1'b1, 1'b0, 8'd0,
        KIND_SYMBOL},
      '{OP_DECODE, 1'b1, 8'hFF, 16'hFFFF, 5'd31, 1'b1, 5'd1, 1'b0, 1'b0, 8'd0,
        KIND_SYMBOL}
   };

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_op;
   logic                req_in_bit;
   logic [SYM_W-1:0]    req_entry_symbol;
   logic [CODE_W-1:0]   req_entry_code;
   logic [LEN_W-1:0]    req_entry_length;
   logic                req_entry_valid;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [SYM_W-1:0]    rsp_out_symbol;
   logic                rsp_out_kind;

   // model of the code table and the bit accumulator
   logic [CODE_W-1:0]   tbl_code [TABLE_DEPTH];
   logic [LEN_W-1:0]    tbl_len  [TABLE_DEPTH];
   logic                tbl_ok   [TABLE_DEPTH];
   logic [CODE_W-1:0]   shift_reg;
   int                  shift_cnt;

   // results still owed by the block, oldest first
   outcome_type         pending_symbols [$];

   // current code set
   int unsigned         set_sym  [$];
   int unsigned         set_code [$];
   int unsigned         set_len  [$];

   bit                  calm;
   int                  mismatches;
   int                  words_sent;
   int                  loads_sent;
   int                  bits_sent;
   int                  symbols_seen;
   int                  overflows_seen;
   int                  sets_run;

   huffman_bit_serial_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_in_bit       (req_in_bit),
      .req_entry_symbol (req_entry_symbol),
      .req_entry_code   (req_entry_code),
      .req_entry_length (req_entry_length),
      .req_entry_valid  (req_entry_valid),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_symbol   (rsp_out_symbol),
      .rsp_out_kind     (rsp_out_kind)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bail out on a hang
   initial begin
      #50_000_000;
      $display("huffman_bit_serial_decoder_tb: FAIL");
      $finish;
   end

   // apply one word to the model; return 1 when it yields a result
   function automatic bit decode_word(input word_type w, output outcome_type res);
      int               s;
      int               ln;
      int               hit;
      bit               found;
      logic [CODE_W:0]  mask;
      res   = '0;
      found = 1'b0;
      hit   = 0;
      if (w.op == OP_LOAD) begin
         tbl_code[w.symbol] = w.code;
         tbl_len[w.symbol]  = w.length;
         tbl_ok[w.symbol]   = w.usable;
         return 1'b0;
      end
      shift_reg = {shift_reg[CODE_W-2:0], w.in_bit};
      shift_cnt = (shift_cnt + 1 > COUNT_CAP) ? COUNT_CAP : shift_cnt + 1;
      // full compare over the table, later hits override earlier ones
      for (s = 0; s < TABLE_DEPTH; s++) begin
         ln = int'(tbl_len[s]);
         if (tbl_ok[s] && ln != 0 && ln <= CODE_W && ln <= MODEL_LEN &&
             ln == shift_cnt) begin
            mask = (17'd1 << ln) - 17'd1;
            if ((tbl_code[s] & mask[CODE_W-1:0]) == (shift_reg & mask[CODE_W-1:0])) begin
               found = 1'b1;
               hit   = s;
            end
         end
      end
      if (found) begin
         res.symbol = SYM_W'(hit);
         res.kind   = KIND_SYMBOL;
      end else if (shift_cnt >= BIT_LIMIT) begin
         res.symbol = '0;
         res.kind   = KIND_OVERFLOW;
      end else begin
         return 1'b0;
      end
      shift_reg = '0;
      shift_cnt = 0;
      return 1'b1;
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 15));
   endfunction

   // send one word after a random gap; queue what it should produce
   task automatic send_word(input word_type w, input bit typed, input bit has_out,
                            input outcome_type typed_out);
      int           gap;
      bit           got;
      outcome_type  res;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= w.op;
      req_in_bit       <= w.in_bit;
      req_entry_symbol <= w.symbol;
      req_entry_code   <= w.code;
      req_entry_length <= w.length;
      req_entry_valid  <= w.usable;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      got = decode_word(w, res);
      if (typed) begin
         got = has_out;
         res = typed_out;
      end
      if (got) pending_symbols.push_back(res);
      words_sent++;
      if (w.op == OP_LOAD) loads_sent++;
      else bits_sent++;
   endtask

   task automatic send_bit(input logic b);
      word_type w;
      w        = word_type'($urandom);
      w.op     = OP_DECODE;
      w.in_bit = b;
      send_word(w, 1'b0, 1'b0, '0);
   endtask

   task automatic send_load(input int unsigned sym, input int unsigned code,
                            input int unsigned len, input logic ok);
      word_type w;
      w.op     = OP_LOAD;
      w.in_bit = 1'($urandom_range(0, 1));
      w.symbol = SYM_W'(sym);
      w.code   = CODE_W'(code);
      w.length = LEN_W'(len);
      w.usable = ok;
      send_word(w, 1'b0, 1'b0, '0);
   endtask

   // hold the sender until every owed result is out
   task automatic wait_for_pending();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_symbols.size() != 0);
   endtask

   // build a random prefix-free code, load it, then stream its code words
   task automatic run_code_set();
      int unsigned  leaf_code [$];
      int unsigned  leaf_len  [$];
      bit           taken [TABLE_DEPTH];
      int           max_len;
      int           goal;
      int           idx;
      int           k;
      int           n_words;
      int unsigned  sym;
      int unsigned  field;
      // retire the previous set now and then, else let it linger and collide
      if ($urandom_range(0, 1) == 1) begin
         foreach (set_sym[i])
            send_load(set_sym[i], $urandom, $urandom_range(0, 31), 1'b0);
      end
      set_sym.delete();
      set_code.delete();
      set_len.delete();
      max_len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(9, 16))
                                            : int'($urandom_range(1, 8));
      goal    = $urandom_range(2, 24);
      // split leaves, favoring the newest one so deep chains appear
      leaf_code.push_back(0);
      leaf_len.push_back(0);
      while (leaf_code.size() < goal) begin
         idx = ($urandom_range(0, 1) == 1) ? leaf_code.size() - 1
                                           : int'($urandom_range(0, leaf_code.size() - 1));
         if (leaf_len[idx] >= max_len) begin
            idx = -1;
            foreach (leaf_len[i]) if (leaf_len[i] < max_len) idx = i;
            if (idx < 0) break;
         end
         leaf_code.push_back((leaf_code[idx] << 1) | 1);
         leaf_len.push_back(leaf_len[idx] + 1);
         leaf_code[idx] = leaf_code[idx] << 1;
         leaf_len[idx]  = leaf_len[idx] + 1;
      end
      // distinct symbols, loaded with junk above the code now and then
      foreach (taken[i]) taken[i] = 1'b0;
      foreach (leaf_code[i]) begin
         do sym = $urandom_range(0, 255); while (taken[sym]);
         taken[sym] = 1'b1;
         set_sym.push_back(sym);
         set_code.push_back(leaf_code[i]);
         set_len.push_back(leaf_len[i]);
         field = leaf_code[i];
         if ($urandom_range(0, 2) == 0) field = field | ($urandom << leaf_len[i]);
         send_load(sym, field & 16'hFFFF, leaf_len[i], $urandom_range(0, 7) != 0);
         if ($urandom_range(0, 9) == 0)
            send_load($urandom_range(0, 255), $urandom, $urandom_range(0, 31),
                      1'($urandom_range(0, 1)));
      end
      // stream code words with the odd stray bit
      n_words = $urandom_range(4, 24);
      repeat (n_words) begin
         if ($urandom_range(0, 9) == 0) begin
            send_bit(1'($urandom_range(0, 1)));
         end else begin
            idx = $urandom_range(0, set_sym.size() - 1);
            for (k = int'(set_len[idx]) - 1; k >= 0; k--)
               send_bit(1'((set_code[idx] >> k) & 1));
         end
      end
      sets_run++;
   endtask

   // take results with random stalls and score them in order
   task automatic serve_results();
      int           hold;
      outcome_type  want;
      forever begin
         hold = draw_wait();
         rsp_stall <= (hold != 0);
         @(negedge clock);
         while (!rsp_valid) @(negedge clock);
         if (hold != 0) begin
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
         end
         while (!(rsp_valid && !rsp_stall)) @(negedge clock);
         // word is taken at the coming edge
         if (rsp_out_kind == KIND_OVERFLOW) overflows_seen++;
         else symbols_seen++;
         if (pending_symbols.size() == 0) begin
            $display("%0t: unexpected result, symbol %0d kind %0d", $time,
                     rsp_out_symbol, rsp_out_kind);
            mismatches++;
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_out_symbol !== want.symbol) begin
               $display("%0t: symbol expected %0d, actual %0d", $time,
                        want.symbol, rsp_out_symbol);
               mismatches++;
            end
            if (rsp_out_kind !== want.kind) begin
               $display("%0t: kind expected %0d, actual %0d", $time,
                        want.kind, rsp_out_kind);
               mismatches++;
            end
         end
         @(posedge clock);
      end
   endtask

   initial begin
      word_type  w;
      row_type   row;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_op           <= OP_LOAD;
      req_in_bit       <= 1'b0;
      req_entry_symbol <= '0;
      req_entry_code   <= '0;
      req_entry_length <= '0;
      req_entry_valid  <= 1'b0;
      rsp_stall        <= 1'b0;
      calm             = 1'b0;
      mismatches       = 0;
      words_sent       = 0;
      loads_sent       = 0;
      bits_sent        = 0;
      symbols_seen     = 0;
      overflows_seen   = 0;
      sets_run         = 0;
      shift_reg        = '0;
      shift_cnt        = 0;
      foreach (tbl_ok[i]) begin
         tbl_code[i] = '0;
         tbl_len[i]  = '0;
         tbl_ok[i]   = 1'b0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         serve_results();
      join_none

      // directed table
      foreach (PLAN[i]) begin
         row      = PLAN[i];
         w.op     = row.op;
         w.in_bit = row.in_bit;
         w.symbol = row.symbol;
         w.code   = row.code;
         w.length = row.length;
         w.usable = row.usable;
         repeat (row.reps)
            send_word(w, row.typed, row.has_out, '{row.out_symbol, row.out_kind});
      end
      wait_for_pending();

      // random code sets, some run back to back with no idling
      while (words_sent < WORD_GOAL) begin
         calm = ($urandom_range(0, 3) == 0);
         run_code_set();
         if (sets_run % 6 == 5) wait_for_pending();
      end
      calm = 1'b0;

      // drain and let any last quiet sweep finish
      req_valid <= 1'b0;
      while (pending_symbols.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Sent %0d words: %0d table loads, %0d code bits over %0d code sets.",
               words_sent, loads_sent, bits_sent, sets_run);
      $display("Scored %0d decoded symbols and %0d overflows, %0d mismatches.",
               symbols_seen, overflows_seen, mismatches);
      if (mismatches == 0) begin
         $display("huffman_bit_serial_decoder_tb: PASS");
      end else begin
         $display("huffman_bit_serial_decoder_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: huffman_bit_serial_decoder.f
rtl/hbd_pkg.sv
rtl/hbd_table.sv
rtl/hbd_accum.sv
rtl/hbd_scan.sv
rtl/huffman_bit_serial_decoder.sv
bench/huffman_bit_serial_decoder_tb.sv
